// File: sv/saoc_pkg.sv
// Shared pixel types, register indexes and mode codes for the overlay compositor.
package saoc_pkg;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t px;
    logic   covered;
  } result_t;

  localparam logic CMD_LOAD        = 1'b0;
  localparam logic CMD_COMPOSITE   = 1'b1;
  localparam logic COMPOSE_REPLACE = 1'b0;
  localparam logic COMPOSE_BLEND   = 1'b1;
  localparam logic SCALE_NEAREST   = 1'b0;
  localparam logic SCALE_BILINEAR  = 1'b1;

  localparam logic [2:0] REG_PLACE_X       = 3'd0;
  localparam logic [2:0] REG_PLACE_Y       = 3'd1;
  localparam logic [2:0] REG_SCALED_WIDTH  = 3'd2;
  localparam logic [2:0] REG_SCALED_HEIGHT = 3'd3;
  localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd4;
  localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd5;
  localparam logic [2:0] REG_COMPOSE_MODE  = 3'd6;
  localparam logic [2:0] REG_SCALE_MODE    = 3'd7;

  localparam logic [12:0] SCALED_RESET = 13'd64;
  localparam logic [6:0]  SOURCE_RESET = 7'd64;
  localparam logic [7:0]  CHAN_MAX     = 8'hFF;

endpackage

// File: sv/scaled_alpha_overlay_compositor.sv
// Throughput: one word per cycle while the output is not stalled; the two pipelined dividers set the depth.
// A load takes no output slot; it writes the store at the same stage composites read it.
// Stalls hold the whole pipeline once the skid entry behind the output register is full.
// Reset: synchronous; restores register defaults and clears all stage valid bits.
// The overlay store is not cleared by reset.
module scaled_alpha_overlay_compositor import saoc_pkg::*; #(
  parameter int SRC_DIM_MAX  = 64,
  parameter int DEST_DIM_MAX = 4096,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [7:0]  in_alpha,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_alpha,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        covered,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int F   = FRAC_BITS;
  localparam int SW  = $clog2(SRC_DIM_MAX + 1);
  localparam int XW  = ($clog2(SRC_DIM_MAX) < 2) ? 2 : $clog2(SRC_DIM_MAX);
  localparam int AW  = 2 * (XW - 1);
  localparam int UW  = 13;
  localparam int MXW = UW + SW;
  localparam int WSW = UW + SW + 1;
  localparam int DNW = UW + SW;
  localparam int NMW = MXW + SW;
  localparam int QW  = SW + F;
  localparam int DW  = SW + UW + 1;
  localparam int CW  = DW + QW;

  typedef struct packed {
    logic          wr;
    logic          comp;
    logic          cov;
    logic [XW-1:0] lx;
    logic [XW-1:0] ly;
    pixel_t        px;
  } side_t;

  typedef struct packed {
    side_t         sd;
    logic [SW-1:0] sw;
    logic [SW-1:0] sh;
  } dly_t;

  typedef struct packed {
    logic [XW-1:0] lo;
    logic [XW-1:0] hi;
    logic [F-1:0]  fr;
  } axis_t;

  function automatic logic [7:0] lerp8(logic [7:0] a, logic [7:0] b, logic [F-1:0] f);
    logic [F:0]   wa;
    logic [F+8:0] acc;
    wa  = {1'b1, {F{1'b0}}} - {1'b0, f};
    acc = (F+9)'(a) * (F+9)'(wa) + (F+9)'(b) * (F+9)'(f);
    return acc[F+7:F];
  endfunction

  function automatic pixel_t lerp_px(pixel_t p, pixel_t q, logic [F-1:0] f);
    pixel_t r;
    r.alpha = lerp8(p.alpha, q.alpha, f);
    r.red   = lerp8(p.red,   q.red,   f);
    r.green = lerp8(p.green, q.green, f);
    r.blue  = lerp8(p.blue,  q.blue,  f);
    return r;
  endfunction

  function automatic axis_t pick(logic [QW-1:0] q, logic [SW-1:0] s, logic bil);
    axis_t         a;
    logic [SW:0]   lo_b;
    logic [SW:0]   nxt;
    logic [SW-1:0] last;
    logic [SW-1:0] qn;
    lo_b = {1'b0, q[QW-1:F]};
    nxt  = lo_b + (SW+1)'(1);
    last = s - SW'(1);
    qn   = q[SW-1:0];
    if (bil) begin
      a.lo = XW'(lo_b);
      a.hi = (nxt >= {1'b0, s}) ? XW'(last) : XW'(nxt);
      a.fr = q[F-1:0];
    end else begin
      a.lo = (qn >= s) ? XW'(last) : XW'(qn);
      a.hi = a.lo;
      a.fr = '0;
    end
    return a;
  endfunction

  // floor(n / 255) for n up to 255 * 255, the largest blend sum
  function automatic logic [7:0] div255(logic [15:0] n);
    logic [15:0] s;
    s = n + 16'd1 + (n >> 8);
    return s[15:8];
  endfunction

  // configuration registers
  logic [12:0] place_x, place_y, scaled_width, scaled_height;
  logic [6:0]  source_width, source_height;
  logic        compose_mode, scale_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      place_x       <= '0;
      place_y       <= '0;
      scaled_width  <= SCALED_RESET;
      scaled_height <= SCALED_RESET;
      source_width  <= SOURCE_RESET;
      source_height <= SOURCE_RESET;
      compose_mode  <= COMPOSE_BLEND;
      scale_mode    <= SCALE_NEAREST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PLACE_X:       place_x       <= cfg_data;
        REG_PLACE_Y:       place_y       <= cfg_data;
        REG_SCALED_WIDTH:  scaled_width  <= cfg_data;
        REG_SCALED_HEIGHT: scaled_height <= cfg_data;
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[6:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[6:0];
        REG_COMPOSE_MODE:  compose_mode  <= cfg_data[0];
        REG_SCALE_MODE:    scale_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic bil;
  assign bil = (scale_mode == SCALE_BILINEAR);

  logic adv;
  assign in_ready = adv;

  // stage 0: input register
  logic        s0_valid, s0_cmd;
  logic [11:0] s0_x, s0_y;
  pixel_t      s0_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_cmd <= command;
      s0_x   <= pos_x;
      s0_y   <= pos_y;
      s0_px  <= {in_alpha, in_red, in_green, in_blue};
    end
  end

  // stage 1: offsets into the overlay rectangle and coverage
  logic signed [13:0] u_full, v_full;
  logic [SW-1:0]      sw_eff, sh_eff;
  logic               in_rect;
  side_t              s1_next, s1_side;
  logic [UW-1:0]      s1_u, s1_v;
  logic [SW-1:0]      s1_sw, s1_sh;

  assign u_full = $signed({2'b00, s0_x}) - $signed({place_x[12], place_x});
  assign v_full = $signed({2'b00, s0_y}) - $signed({place_y[12], place_y});

  always_comb begin
    sw_eff = (int'(source_width) > SRC_DIM_MAX) ? SW'(SRC_DIM_MAX) : SW'(source_width);
    sh_eff = (int'(source_height) > SRC_DIM_MAX) ? SW'(SRC_DIM_MAX) : SW'(source_height);
    in_rect = (int'(s0_x) < DEST_DIM_MAX) && (int'(s0_y) < DEST_DIM_MAX) &&
              (sw_eff != '0) && (sh_eff != '0) && !u_full[13] && !v_full[13] &&
              (u_full[12:0] < scaled_width) && (v_full[12:0] < scaled_height);
    s1_next.wr   = s0_valid && (s0_cmd == CMD_LOAD) &&
                   (int'(s0_x) < SRC_DIM_MAX) && (int'(s0_y) < SRC_DIM_MAX);
    s1_next.comp = s0_valid && (s0_cmd == CMD_COMPOSITE);
    s1_next.cov  = s1_next.comp && in_rect;
    s1_next.lx   = XW'(s0_x);
    s1_next.ly   = XW'(s0_y);
    s1_next.px   = s0_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_side <= '0;
    end else if (adv) begin
      s1_side <= s1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_u  <= u_full[12:0];
      s1_v  <= v_full[12:0];
      s1_sw <= sw_eff;
      s1_sh <= sh_eff;
    end
  end

  // stage 2: first products
  side_t          s2_side;
  logic [MXW-1:0] s2_mx, s2_my;
  logic [WSW-1:0] s2_wsx, s2_wsy;
  logic [DNW-1:0] s2_dx, s2_dy;
  logic [SW-1:0]  s2_sw, s2_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_side <= '0;
    end else if (adv) begin
      s2_side <= s1_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mx  <= MXW'(s1_u) * MXW'(s1_sw);
      s2_my  <= MXW'(s1_v) * MXW'(s1_sh);
      s2_wsx <= WSW'(scaled_width) * (WSW'(s1_sw) + WSW'(1));
      s2_wsy <= WSW'(scaled_height) * (WSW'(s1_sh) + WSW'(1));
      s2_dx  <= DNW'(scaled_width) * DNW'(s1_sw);
      s2_dy  <= DNW'(scaled_height) * DNW'(s1_sh);
      s2_sw  <= s1_sw;
      s2_sh  <= s1_sh;
    end
  end

  // stage 3: dividend and divisor for the chosen scaling
  logic [NMW-1:0] nmx, nmy;
  dly_t           s3;
  logic [CW-1:0]  s3_nx, s3_ny;
  logic [DW-1:0]  s3_dx, s3_dy;

  assign nmx = NMW'(s2_mx) * NMW'(s2_sw);
  assign nmy = NMW'(s2_my) * NMW'(s2_sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3 <= '0;
    end else if (adv) begin
      s3.sd <= s2_side;
      s3.sw <= s2_sw;
      s3.sh <= s2_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_nx <= bil ? (CW'(s2_mx) << F) : ((CW'(nmx) << 1) + CW'(s2_wsx));
      s3_ny <= bil ? (CW'(s2_my) << F) : ((CW'(nmy) << 1) + CW'(s2_wsy));
      s3_dx <= bil ? DW'(scaled_width)  : {s2_dx, 1'b0};
      s3_dy <= bil ? DW'(scaled_height) : {s2_dy, 1'b0};
    end
  end

  // dividers with a matching side delay line
  logic [QW-1:0] qx, qy;
  dly_t          dly [QW];

  saoc_div #(.CW(CW), .DW(DW), .QW(QW)) u_div_x (
    .clk (clk), .en (adv), .num (s3_nx), .den (s3_dx), .quo (qx)
  );

  saoc_div #(.CW(CW), .DW(DW), .QW(QW)) u_div_y (
    .clk (clk), .en (adv), .num (s3_ny), .den (s3_dy), .quo (qy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QW; i++) begin
        dly[i] <= '0;
      end
    end else if (adv) begin
      dly[0] <= s3;
      for (int i = 1; i < QW; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  // stage 4: sample indexes and fractions
  side_t s4_side;
  axis_t s4_ax, s4_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_side <= '0;
    end else if (adv) begin
      s4_side <= dly[QW-1].sd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ax <= pick(qx, dly[QW-1].sw, bil);
      s4_ay <= pick(qy, dly[QW-1].sh, bil);
    end
  end

  // stage 5: store access; loads write where composites read to keep order
  logic [3:0][AW-1:0] raddr;
  pixel_t [3:0]       rdata;
  side_t              s5_side;
  logic               s5_t0, s5_b0, s5_l0, s5_r0;
  logic [F-1:0]       s5_fx, s5_fy;

  for (genvar b = 0; b < 4; b++) begin : g_addr
    logic [XW-1:0] row, col;
    assign row = (s4_ay.lo[0] == 1'((b >> 1))) ? s4_ay.lo : s4_ay.hi;
    assign col = (s4_ax.lo[0] == 1'(b)) ? s4_ax.lo : s4_ax.hi;
    assign raddr[b] = {row[XW-1:1], col[XW-1:1]};
  end

  saoc_store #(.AW(AW)) u_store (
    .clk   (clk),
    .en    (adv),
    .we    (s4_side.wr),
    .wbank ({s4_side.ly[0], s4_side.lx[0]}),
    .waddr ({s4_side.ly[XW-1:1], s4_side.lx[XW-1:1]}),
    .wdata (s4_side.px),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_side <= '0;
    end else if (adv) begin
      s5_side <= s4_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_t0 <= s4_ay.lo[0];
      s5_b0 <= s4_ay.hi[0];
      s5_l0 <= s4_ax.lo[0];
      s5_r0 <= s4_ax.hi[0];
      s5_fx <= s4_ax.fr;
      s5_fy <= s4_ay.fr;
    end
  end

  // stage 6: horizontal interpolation
  side_t        s6_side;
  pixel_t       s6_top, s6_bot;
  logic [F-1:0] s6_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_side <= '0;
    end else if (adv) begin
      s6_side <= s5_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_top <= lerp_px(rdata[{s5_t0, s5_l0}], rdata[{s5_t0, s5_r0}], s5_fx);
      s6_bot <= lerp_px(rdata[{s5_b0, s5_l0}], rdata[{s5_b0, s5_r0}], s5_fx);
      s6_fy  <= s5_fy;
    end
  end

  // stage 7: vertical interpolation
  side_t  s7_side;
  pixel_t s7_ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_side <= '0;
    end else if (adv) begin
      s7_side <= s6_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_ov <= lerp_px(s6_top, s6_bot, s6_fy);
    end
  end

  // stage 8: blend products and saturated alpha
  side_t       s8_side;
  pixel_t      s8_ov;
  logic [15:0] s8_nr, s8_ng, s8_nb;
  logic [7:0]  s8_sat;
  logic [7:0]  a_ov;
  logic [8:0]  a_sum;

  assign a_ov  = s7_ov.alpha;
  assign a_sum = {1'b0, s7_side.px.alpha} + {1'b0, a_ov};

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_side <= '0;
    end else if (adv) begin
      s8_side <= s7_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_ov  <= s7_ov;
      s8_nr  <= 16'(a_ov) * 16'(s7_ov.red)   + 16'(CHAN_MAX - a_ov) * 16'(s7_side.px.red);
      s8_ng  <= 16'(a_ov) * 16'(s7_ov.green) + 16'(CHAN_MAX - a_ov) * 16'(s7_side.px.green);
      s8_nb  <= 16'(a_ov) * 16'(s7_ov.blue)  + 16'(CHAN_MAX - a_ov) * 16'(s7_side.px.blue);
      s8_sat <= a_sum[8] ? CHAN_MAX : a_sum[7:0];
    end
  end

  // stage 9: compose
  result_t s9_next, s9_res;
  logic    s9_vld;

  always_comb begin
    s9_next.covered = s8_side.cov;
    if (!s8_side.cov) begin
      s9_next.px = s8_side.px;
    end else if ((compose_mode == COMPOSE_REPLACE) || (s8_ov.alpha == CHAN_MAX)) begin
      s9_next.px = s8_ov;
    end else if (s8_ov.alpha == '0) begin
      s9_next.px = s8_side.px;
    end else begin
      s9_next.px = {s8_sat, div255(s8_nr), div255(s8_ng), div255(s8_nb)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_vld <= 1'b0;
    end else if (adv) begin
      s9_vld <= s8_side.comp;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_res <= s9_next;
    end
  end

  result_t out_data;

  saoc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s9_vld),
    .in_ready  (adv),
    .in_data   (s9_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_alpha = out_data.px.alpha;
  assign out_red   = out_data.px.red;
  assign out_green = out_data.px.green;
  assign out_blue  = out_data.px.blue;
  assign covered   = out_data.covered;

`ifndef ASSERT_OFF
  // the skid entry fills only behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    !adv |-> out_valid)
    else $error("pipeline stalled without a held output word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && adv))
    else $error("output or skid not empty after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!adv && !rst) |=> ($stable(s9_vld) && $stable(s9_res)))
    else $error("last stage changed during a stall");
`endif

endmodule

// File: sv/saoc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module saoc_div #(
  parameter int CW = 44,
  parameter int DW = 21,
  parameter int QW = 23
) (
  input  logic          clk,
  input  logic          en,
  input  logic [CW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [CW-1:0] rem [QW-1];
  logic [DW-1:0] dv  [QW-1];
  logic [QW-1:0] q   [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [CW-1:0] r_in;
    logic [CW-1:0] d_sh;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic          fit;

    if (i == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[i-1];
      assign d_in = dv[i-1];
      assign q_in = q[i-1];
    end

    // trial subtract of the divisor aligned to this quotient bit
    assign d_sh = CW'(d_in) << (QW - 1 - i);
    assign fit  = (r_in >= d_sh);

    always_ff @(posedge clk) begin
      if (en) begin
        q[i] <= q_in | (fit ? (QW'(1) << (QW - 1 - i)) : '0);
      end
    end

    if (i < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= fit ? (r_in - d_sh) : r_in;
          dv[i]  <= d_in;
        end
      end
    end
  end

  assign quo = q[QW-1];

endmodule

// File: sv/saoc_store.sv
// Overlay pixel store split into four banks by row and column parity.
module saoc_store import saoc_pkg::*; #(
  parameter int AW = 10
) (
  input  logic                clk,
  input  logic                en,
  input  logic                we,
  input  logic [1:0]          wbank,
  input  logic [AW-1:0]       waddr,
  input  pixel_t              wdata,
  input  logic [3:0][AW-1:0]  raddr,
  output pixel_t [3:0]        rdata
);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    pixel_t mem [2**AW];
    pixel_t rd;

    always_ff @(posedge clk) begin
      if (en) begin
        if (we && (wbank == 2'(b))) begin
          mem[waddr] <= wdata;
        end
        rd <= mem[raddr[b]];
      end
    end

    assign rdata[b] = rd;
  end

endmodule

// File: sv/saoc_skid.sv
// Output register with a skid entry so the pipeline keeps moving one word past a stall.
module saoc_skid import saoc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t skid;
  logic    skid_full;

  assign in_ready = !skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_full ? skid : in_data;
    end else if (in_valid && !skid_full) begin
      // hold the word that arrived behind a stalled output
      skid <= in_data;
    end
  end

endmodule

// File: tb/scaled_alpha_overlay_compositor_tb.sv
// Self-checking testbench for the scaled alpha overlay compositor.
`timescale 1ns / 100ps

module scaled_alpha_overlay_compositor_tb;
  import saoc_pkg::*;

  localparam int SRC_DIM   = 64;
  localparam int DEST_DIM  = 4096;
  localparam int FRAC      = 16;
  localparam int DRAIN_CYC = 40;

  typedef struct {
    logic       cmd;
    logic [11:0] x;
    logic [11:0] y;
    pixel_t     px;
  } pixel_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = CMD_LOAD;
  logic [11:0] pos_x = '0;
  logic [11:0] pos_y = '0;
  logic [7:0]  in_alpha = '0;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_alpha;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        covered;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  // shadow registers of the block
  logic signed [12:0] sh_place_x = '0;
  logic signed [12:0] sh_place_y = '0;
  logic [12:0] sh_scaled_w = SCALED_RESET;
  logic [12:0] sh_scaled_h = SCALED_RESET;
  logic [6:0]  sh_src_w = SOURCE_RESET;
  logic [6:0]  sh_src_h = SOURCE_RESET;
  logic        sh_compose = COMPOSE_BLEND;
  logic        sh_scale = SCALE_NEAREST;

  pixel_t      overlay_img [SRC_DIM*SRC_DIM];
  pixel_word_t pending_words[$];
  result_t     expected_pixels[$];
  pixel_word_t cur_word;
  int          words_queued = 0;
  int          words_accepted = 0;
  int          mismatches = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          calm = 1'b0;

  scaled_alpha_overlay_compositor i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic pixel_t lerp_pixel(pixel_t p, pixel_t q, longint unsigned f);
    pixel_t r;
    logic [31:0] pv, qv, rv;
    longint unsigned c;
    pv = p;
    qv = q;
    for (int sh = 0; sh < 32; sh += 8) begin
      c = (longint'(pv[sh +: 8]) * ((64'd1 << FRAC) - f) + longint'(qv[sh +: 8]) * f) >> FRAC;
      rv[sh +: 8] = c[7:0];
    end
    r = rv;
    return r;
  endfunction

  function automatic int nearest_index(longint unsigned u, longint unsigned w,
                                       longint unsigned s);
    longint unsigned idx;
    idx = (2 * u * s * s + w * (s + 1)) / (2 * s * w);
    return (idx > s - 1) ? int'(s - 1) : int'(idx);
  endfunction

  function automatic pixel_t sample_overlay(longint unsigned u, longint unsigned v,
                                            longint unsigned sw, longint unsigned sh);
    longint unsigned w, h, ppx, ppy;
    int l, r, t, b;
    pixel_t top, bot;
    w = sh_scaled_w;
    h = sh_scaled_h;
    if (sh_scale == SCALE_NEAREST)
      return overlay_img[nearest_index(v, h, sh) * SRC_DIM + nearest_index(u, w, sw)];
    ppx = ((u * sw) << FRAC) / w;
    ppy = ((v * sh) << FRAC) / h;
    l = int'(ppx >> FRAC);
    t = int'(ppy >> FRAC);
    r = (l + 1 > sw - 1) ? int'(sw - 1) : l + 1;
    b = (t + 1 > sh - 1) ? int'(sh - 1) : t + 1;
    top = lerp_pixel(overlay_img[t*SRC_DIM + l], overlay_img[t*SRC_DIM + r],
                     ppx & ((64'd1 << FRAC) - 1));
    bot = lerp_pixel(overlay_img[b*SRC_DIM + l], overlay_img[b*SRC_DIM + r],
                     ppx & ((64'd1 << FRAC) - 1));
    return lerp_pixel(top, bot, ppy & ((64'd1 << FRAC) - 1));
  endfunction

  function automatic result_t composite_pixel(pixel_word_t w);
    result_t res;
    pixel_t ov;
    int sw, sh, u, v, a, na, pxi, pyi;
    logic [31:0] ovv, bv, rv;
    res.px = w.px;
    res.covered = 1'b0;
    sw = (sh_src_w > SRC_DIM) ? SRC_DIM : sh_src_w;
    sh = (sh_src_h > SRC_DIM) ? SRC_DIM : sh_src_h;
    pxi = sh_place_x;
    pyi = sh_place_y;
    u = int'(w.x) - pxi;
    v = int'(w.y) - pyi;
    if (w.x < DEST_DIM && w.y < DEST_DIM && sw != 0 && sh != 0 && u >= 0 && v >= 0 &&
        u < int'(sh_scaled_w) && v < int'(sh_scaled_h)) begin
      ov = sample_overlay(u, v, sw, sh);
      a = ov.alpha;
      res.covered = 1'b1;
      if (sh_compose == COMPOSE_REPLACE || a == 255) begin
        res.px = ov;
      end else if (a != 0) begin
        ovv = ov;
        bv = w.px;
        na = int'(w.px.alpha) + a;
        rv[31:24] = (na > 255) ? CHAN_MAX : na[7:0];
        for (int s = 0; s < 24; s += 8)
          rv[s +: 8] = 8'((a * ovv[s +: 8] + (255 - a) * bv[s +: 8]) / 255);
        res.px = rv;
      end
    end
    return res;
  endfunction

  function automatic void apply_word(pixel_word_t w);
    if (w.cmd == CMD_LOAD) begin
      if (w.x < SRC_DIM && w.y < SRC_DIM) overlay_img[w.y*SRC_DIM + w.x] = w.px;
    end else begin
      expected_pixels.push_back(composite_pixel(w));
    end
  endfunction

  // driver: hold the word until accepted, then advance after a random gap
  always @(posedge clk) begin
    logic nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nxt = in_valid;
      if (in_valid && in_ready) begin
        apply_word(cur_word);
        words_accepted++;
        nxt = 1'b0;
      end
      if (!nxt) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          command  <= cur_word.cmd;
          pos_x    <= cur_word.x;
          pos_y    <= cur_word.y;
          in_alpha <= cur_word.px.alpha;
          in_red   <= cur_word.px.red;
          in_green <= cur_word.px.green;
          in_blue  <= cur_word.px.blue;
          nxt = 1'b1;
          send_gap = pick_gap();
        end
      end
      in_valid <= nxt;
    end
  end

  // monitor: compare each result word with the oldest expected pixel
  always @(posedge clk) begin
    result_t exp_px;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result word");
          mismatches++;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (out_alpha !== exp_px.px.alpha) begin
            $error("out_alpha expected %0d got %0d", exp_px.px.alpha, out_alpha);
            mismatches++;
          end
          if (out_red !== exp_px.px.red) begin
            $error("out_red expected %0d got %0d", exp_px.px.red, out_red);
            mismatches++;
          end
          if (out_green !== exp_px.px.green) begin
            $error("out_green expected %0d got %0d", exp_px.px.green, out_green);
            mismatches++;
          end
          if (out_blue !== exp_px.px.blue) begin
            $error("out_blue expected %0d got %0d", exp_px.px.blue, out_blue);
            mismatches++;
          end
          if (covered !== exp_px.covered) begin
            $error("covered expected %0d got %0d", exp_px.covered, covered);
            mismatches++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) recv_gap = pick_gap();
      end
    end
  end

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = $urandom();
    case ($urandom_range(0, 3))
      0: p.alpha = 8'd0;
      1: p.alpha = CHAN_MAX;
      default: ;
    endcase
    return p;
  endfunction

  function automatic void queue_word(logic cmd, int x, int y, pixel_t p);
    pixel_word_t w;
    w.cmd = cmd;
    w.x = (x < 0) ? 12'd0 : (x > DEST_DIM - 1) ? 12'(DEST_DIM - 1) : 12'(x);
    w.y = (y < 0) ? 12'd0 : (y > DEST_DIM - 1) ? 12'(DEST_DIM - 1) : 12'(y);
    w.px = p;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (words_accepted != words_queued || in_valid || expected_pixels.size() != 0);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic set_config(int px, int py, int sw, int sh, int srcw, int srch,
                            logic comp, logic scl);
    logic [12:0] vals [8];
    vals = '{13'(px), 13'(py), 13'(sw), 13'(sh), 13'(srcw), 13'(srch), 13'(comp), 13'(scl)};
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    sh_place_x = 13'(px);
    sh_place_y = 13'(py);
    sh_scaled_w = 13'(sw);
    sh_scaled_h = 13'(sh);
    sh_src_w = 7'(srcw);
    sh_src_h = 7'(srch);
    sh_compose = comp;
    sh_scale = scl;
  endtask

  // fill the whole sampled region so no unwritten entry is ever read
  task automatic load_region();
    int sw, sh;
    sw = (sh_src_w > SRC_DIM) ? SRC_DIM : sh_src_w;
    sh = (sh_src_h > SRC_DIM) ? SRC_DIM : sh_src_h;
    for (int r = 0; r < sh; r++)
      for (int c = 0; c < sw; c++) queue_word(CMD_LOAD, c, r, rand_pixel());
  endtask

  task automatic random_words(int n);
    int sw, sh, px, py, k;
    sw = (sh_src_w > SRC_DIM) ? SRC_DIM : sh_src_w;
    sh = (sh_src_h > SRC_DIM) ? SRC_DIM : sh_src_h;
    px = sh_place_x;
    py = sh_place_y;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 80)
        queue_word(CMD_COMPOSITE, px + int'($urandom_range(0, sh_scaled_w + 8)) - 4,
                   py + int'($urandom_range(0, sh_scaled_h + 8)) - 4, pixel_t'($urandom()));
      else if (k < 88)
        queue_word(CMD_COMPOSITE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                   pixel_t'($urandom()));
      else if (k < 95 && sw > 0 && sh > 0)
        queue_word(CMD_LOAD, $urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
                   rand_pixel());
      else
        queue_word(CMD_LOAD, $urandom_range(SRC_DIM, 4095), $urandom_range(0, 4095),
                   rand_pixel());
    end
  endtask

  initial begin
    int srcw, srch;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: small bilinear blend, corners, edges and ignored loads
    set_config(2, 3, 5, 4, 4, 3, COMPOSE_BLEND, SCALE_BILINEAR);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++)
        queue_word(CMD_LOAD, c, r, pixel_t'({(r + c) % 3 == 0 ? 8'd0 :
                   (r + c) % 3 == 1 ? CHAN_MAX : 8'd128, 8'hFF, 8'h00, 8'(c * 60 + r)}));
    queue_word(CMD_LOAD, 64, 0, pixel_t'(32'hFFFFFFFF));
    queue_word(CMD_LOAD, 4095, 4095, pixel_t'(32'hFFFFFFFF));
    queue_word(CMD_COMPOSITE, 2, 3, pixel_t'(32'h00000000));
    queue_word(CMD_COMPOSITE, 6, 6, pixel_t'(32'hFFFFFFFF));
    queue_word(CMD_COMPOSITE, 7, 3, pixel_t'(32'h80808080));
    queue_word(CMD_COMPOSITE, 2, 7, pixel_t'(32'hF0102030));
    queue_word(CMD_COMPOSITE, 1, 3, pixel_t'(32'h11223344));
    queue_word(CMD_COMPOSITE, 4, 4, pixel_t'(32'hC0FF00FF));
    queue_word(CMD_COMPOSITE, 0, 0, pixel_t'(32'h55AA55AA));
    queue_word(CMD_COMPOSITE, 4095, 4095, pixel_t'(32'hAA55AA55));
    queue_word(CMD_COMPOSITE, 5, 5, pixel_t'(32'hFF000000));
    wait_drained();

    // extremes of the register ranges
    set_config(-4096, 4095, 4096, 4096, 127, 1, COMPOSE_REPLACE, SCALE_NEAREST);
    load_region();
    random_words(10);
    wait_drained();
    set_config(-100, -50, 4096, 8191, 1, 64, COMPOSE_BLEND, SCALE_BILINEAR);
    load_region();
    random_words(15);
    wait_drained();
    set_config(4095, -4096, 0, 0, 0, 0, COMPOSE_BLEND, SCALE_NEAREST);
    random_words(10);
    wait_drained();

    // random phases, mostly small shapes near the origin
    for (int ph = 0; ph < 6; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      srcw = $urandom_range(1, 12);
      srch = $urandom_range(1, 64 / srcw > 12 ? 12 : 64 / srcw);
      set_config($urandom_range(0, 60) - 20, $urandom_range(0, 60) - 20,
                 $urandom_range(1, 80), $urandom_range(1, 80), srcw, srch,
                 logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
      load_region();
      random_words(32);
      wait_drained();
    end

    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
sv/saoc_pkg.sv
sv/saoc_div.sv
sv/saoc_store.sv
sv/saoc_skid.sv
sv/scaled_alpha_overlay_compositor.sv
tb/scaled_alpha_overlay_compositor_tb.sv
